FILE: rtl/core/sfpr_pkg.sv
// Package for the synchronized framed packet receiver.
// Holds the item structs, the parser phase codes and the register and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfpr_pkg;

  // One received byte and its arrival tick
  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [15:0] arrival_time;
  } rx_item_t;

  // One result item: buffer write, frame end and timeout flags
  typedef struct packed {
    logic       buf_write;
    logic [8:0] buf_index;
    logic [7:0] buf_data;
    logic       packet_done;
    logic [1:0] frame_status;
    logic       timed_out;
  } res_item_t;

  // Parser phases
  localparam logic [3:0] PH_SYNC1   = 4'd0;
  localparam logic [3:0] PH_SYNC2   = 4'd1;
  localparam logic [3:0] PH_ADDR    = 4'd2;
  localparam logic [3:0] PH_PLEN    = 4'd3;
  localparam logic [3:0] PH_CMD     = 4'd4;
  localparam logic [3:0] PH_ACK     = 4'd5;
  localparam logic [3:0] PH_OLEN    = 4'd6;
  localparam logic [3:0] PH_OID1    = 4'd7;
  localparam logic [3:0] PH_OID2    = 4'd8;
  localparam logic [3:0] PH_CONTENT = 4'd9;
  localparam logic [3:0] PH_CHKSUM  = 4'd10;

  // Buffer positions of the header bytes
  localparam logic [8:0] IDX_ADDR       = 9'd0;
  localparam logic [8:0] IDX_PLEN       = 9'd1;
  localparam logic [8:0] IDX_CMD        = 9'd2;
  localparam logic [8:0] IDX_ACK        = 9'd3;
  localparam logic [8:0] IDX_OLEN       = 9'd4;
  localparam logic [8:0] IDX_OID1       = 9'd5;
  localparam logic [8:0] IDX_OID2       = 9'd6;
  localparam logic [8:0] CONTENT_START  = 9'd7;
  localparam logic [8:0] OLEN_OFFSET    = 9'd4;
  localparam logic [8:0] PLEN_SLACK     = 9'd2;
  localparam logic [7:0] ACK_STORED     = 8'h00;

  // Frame status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_OVERRUN = 2'd1;
  localparam logic [1:0] STATUS_CHKSUM  = 2'd2;
  localparam logic [1:0] STATUS_NONE    = 2'd3;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_SYNC_FIRST  = 3'd0;
  localparam logic [2:0] REG_SYNC_SECOND = 3'd1;
  localparam logic [2:0] REG_COMMAND     = 3'd2;
  localparam logic [2:0] REG_ACK         = 3'd3;
  localparam logic [2:0] REG_GAP_TIMEOUT = 3'd4;

  // Register reset values
  localparam logic [7:0]  SYNC_FIRST_RST  = 8'h00;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h00;
  localparam logic [7:0]  COMMAND_RST     = 8'hA0;
  localparam logic [7:0]  ACK_RST         = 8'h00;
  localparam logic [15:0] GAP_TIMEOUT_RST = 16'd10;

endpackage

`default_nettype wire

FILE: rtl/core/sync_framed_packet_receiver.sv
// A result is built combinationally from its byte and registered in the output stage.
// One byte per cycle while rx_stall is low; the parser update is a single registered pass.
// A two-entry output stage (output register plus skid register) keeps the input open
// while one result waits; rx_stall rises only when both entries are full.
// Reset (rst, synchronous, active high) returns the parser to sync hunting, clears
// the output stage and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

// Top level of the framed packet receiver. Depends on sfpr_pkg.
module sync_framed_packet_receiver (
  input  wire                 clk,
  input  wire                 rst,
  // received byte channel
  input  wire                 rx_valid,
  output logic                rx_stall,
  input  sfpr_pkg::rx_item_t  rx_item,
  // result channel
  output logic                res_valid,
  input  wire                 res_stall,
  output sfpr_pkg::res_item_t res_item,
  // register port
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [4:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Configuration registers
  logic [7:0]  sync_first;
  logic [7:0]  sync_second;
  logic [7:0]  command_code;
  logic [7:0]  ack_code;
  logic [15:0] gap_timeout;

  // Parser state
  logic [3:0]  parse_phase;
  logic [3:0]  parse_phase_next;
  logic [7:0]  running_xor;
  logic [7:0]  running_xor_next;
  logic [8:0]  content_index;
  logic [8:0]  content_index_next;
  logic [7:0]  packet_length;
  logic [7:0]  packet_length_next;
  logic [7:0]  object_length;
  logic [7:0]  object_length_next;
  logic [15:0] last_arrival;
  logic        length_error_seen;
  logic        length_error_seen_next;

  // Output stage
  sfpr_pkg::res_item_t result;
  sfpr_pkg::res_item_t skid_item;
  logic                skid_valid;

  logic        in_fire;
  logic        out_free;
  logic        cfg_write;
  logic [2:0]  reg_index;
  logic [15:0] gap;
  logic        gap_expired;
  logic [3:0]  phase_eff;
  logic [8:0]  index_inc;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first   <= sfpr_pkg::SYNC_FIRST_RST;
      sync_second  <= sfpr_pkg::SYNC_SECOND_RST;
      command_code <= sfpr_pkg::COMMAND_RST;
      ack_code     <= sfpr_pkg::ACK_RST;
      gap_timeout  <= sfpr_pkg::GAP_TIMEOUT_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        sfpr_pkg::REG_SYNC_FIRST:  sync_first   <= pwdata[7:0];
        sfpr_pkg::REG_SYNC_SECOND: sync_second  <= pwdata[7:0];
        sfpr_pkg::REG_COMMAND:     command_code <= pwdata[7:0];
        sfpr_pkg::REG_ACK:         ack_code     <= pwdata[7:0];
        sfpr_pkg::REG_GAP_TIMEOUT: gap_timeout  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_index)
      sfpr_pkg::REG_SYNC_FIRST:  prdata = {24'd0, sync_first};
      sfpr_pkg::REG_SYNC_SECOND: prdata = {24'd0, sync_second};
      sfpr_pkg::REG_COMMAND:     prdata = {24'd0, command_code};
      sfpr_pkg::REG_ACK:         prdata = {24'd0, ack_code};
      sfpr_pkg::REG_GAP_TIMEOUT: prdata = {16'd0, gap_timeout};
      default:                   prdata = 32'd0;
    endcase
  end

  // Handshake: output slot frees when empty or being taken
  assign rx_stall = skid_valid;
  assign in_fire  = rx_valid && !rx_stall;
  assign out_free = !res_valid || !res_stall;

  // Gap test, then force hunting on a long silence
  assign gap         = rx_item.arrival_time - last_arrival;
  assign gap_expired = gap > gap_timeout;
  assign phase_eff   = gap_expired ? sfpr_pkg::PH_SYNC1 : parse_phase;
  assign index_inc   = content_index + 9'd1;

  // Parse one byte
  always_comb begin
    parse_phase_next       = phase_eff;
    running_xor_next       = running_xor;
    content_index_next     = content_index;
    packet_length_next     = packet_length;
    object_length_next     = object_length;
    length_error_seen_next = length_error_seen;
    result.buf_write       = 1'b0;
    result.buf_index       = 9'd0;
    result.buf_data        = 8'd0;
    result.packet_done     = 1'b0;
    result.frame_status    = sfpr_pkg::STATUS_OK;
    result.timed_out       = gap_expired;
    unique case (phase_eff)
      sfpr_pkg::PH_SYNC2: begin
        parse_phase_next = (rx_item.rx_byte == sync_second) ? sfpr_pkg::PH_ADDR
                                                            : sfpr_pkg::PH_SYNC1;
      end
      sfpr_pkg::PH_ADDR: begin
        running_xor_next = rx_item.rx_byte;
        result.buf_write = 1'b1;
        result.buf_index = sfpr_pkg::IDX_ADDR;
        result.buf_data  = rx_item.rx_byte;
        parse_phase_next = sfpr_pkg::PH_PLEN;
      end
      sfpr_pkg::PH_PLEN: begin
        running_xor_next   = running_xor ^ rx_item.rx_byte;
        packet_length_next = rx_item.rx_byte;
        result.buf_write   = 1'b1;
        result.buf_index   = sfpr_pkg::IDX_PLEN;
        result.buf_data    = rx_item.rx_byte;
        parse_phase_next   = (rx_item.rx_byte != 8'd0) ? sfpr_pkg::PH_CMD
                                                       : sfpr_pkg::PH_SYNC1;
      end
      sfpr_pkg::PH_CMD: begin
        if (rx_item.rx_byte == command_code) begin
          running_xor_next = running_xor ^ rx_item.rx_byte;
          result.buf_write = 1'b1;
          result.buf_index = sfpr_pkg::IDX_CMD;
          result.buf_data  = rx_item.rx_byte;
          parse_phase_next = sfpr_pkg::PH_ACK;
        end else begin
          parse_phase_next = sfpr_pkg::PH_SYNC1;
        end
      end
      sfpr_pkg::PH_ACK: begin
        if (rx_item.rx_byte == ack_code) begin
          running_xor_next       = running_xor ^ rx_item.rx_byte;
          result.buf_write       = 1'b1;
          result.buf_index       = sfpr_pkg::IDX_ACK;
          result.buf_data        = sfpr_pkg::ACK_STORED;
          length_error_seen_next = 1'b0;
          parse_phase_next       = sfpr_pkg::PH_OLEN;
        end else begin
          parse_phase_next = sfpr_pkg::PH_SYNC1;
        end
      end
      sfpr_pkg::PH_OLEN: begin
        running_xor_next   = running_xor ^ rx_item.rx_byte;
        object_length_next = rx_item.rx_byte;
        result.buf_write   = 1'b1;
        result.buf_index   = sfpr_pkg::IDX_OLEN;
        result.buf_data    = rx_item.rx_byte;
        parse_phase_next   = (rx_item.rx_byte != 8'd0) ? sfpr_pkg::PH_OID1
                                                       : sfpr_pkg::PH_SYNC1;
      end
      sfpr_pkg::PH_OID1: begin
        running_xor_next = running_xor ^ rx_item.rx_byte;
        result.buf_write = 1'b1;
        result.buf_index = sfpr_pkg::IDX_OID1;
        result.buf_data  = rx_item.rx_byte;
        parse_phase_next = sfpr_pkg::PH_OID2;
      end
      sfpr_pkg::PH_OID2: begin
        running_xor_next   = running_xor ^ rx_item.rx_byte;
        result.buf_write   = 1'b1;
        result.buf_index   = sfpr_pkg::IDX_OID2;
        result.buf_data    = rx_item.rx_byte;
        content_index_next = sfpr_pkg::CONTENT_START;
        parse_phase_next   = sfpr_pkg::PH_CONTENT;
      end
      sfpr_pkg::PH_CONTENT: begin
        running_xor_next   = running_xor ^ rx_item.rx_byte;
        result.buf_write   = 1'b1;
        result.buf_index   = content_index;
        result.buf_data    = rx_item.rx_byte;
        content_index_next = index_inc;
        // Object fully received: checksum comes next
        if (index_inc == {1'b0, object_length} + sfpr_pkg::OLEN_OFFSET) begin
          parse_phase_next = sfpr_pkg::PH_CHKSUM;
        end
        // Overrun of the packet length ends the frame at once
        if (index_inc > {1'b0, packet_length} + sfpr_pkg::PLEN_SLACK) begin
          parse_phase_next       = sfpr_pkg::PH_SYNC1;
          result.packet_done     = 1'b1;
          result.frame_status    = sfpr_pkg::STATUS_OVERRUN;
          length_error_seen_next = 1'b1;
        end
      end
      sfpr_pkg::PH_CHKSUM: begin
        result.packet_done  = 1'b1;
        result.frame_status = (rx_item.rx_byte != running_xor) ? sfpr_pkg::STATUS_CHKSUM
                                                               : sfpr_pkg::STATUS_OK;
        parse_phase_next    = sfpr_pkg::PH_SYNC1;
      end
      default: begin
        // Hunting for the first sync byte, also for unused phase codes
        parse_phase_next = (rx_item.rx_byte == sync_first) ? sfpr_pkg::PH_SYNC2
                                                           : sfpr_pkg::PH_SYNC1;
      end
    endcase
  end

  // Advance parser state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= sfpr_pkg::PH_SYNC1;
      running_xor       <= 8'd0;
      content_index     <= 9'd0;
      packet_length     <= 8'd0;
      object_length     <= 8'd0;
      last_arrival      <= 16'd0;
      length_error_seen <= 1'b0;
    end else if (in_fire) begin
      parse_phase       <= parse_phase_next;
      running_xor       <= running_xor_next;
      content_index     <= content_index_next;
      packet_length     <= packet_length_next;
      object_length     <= object_length_next;
      last_arrival      <= rx_item.arrival_time;
      length_error_seen <= length_error_seen_next;
    end
  end

  // Output register and skid register control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        res_item <= skid_item;
      end else if (in_fire) begin
        res_item <= result;
      end
    end else if (in_fire) begin
      skid_item <= result;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sfpr_checker.sv
// Port-level checker for the framed packet receiver, with its bind.
// Depends on sfpr_pkg and the sync_framed_packet_receiver ports.
`timescale 1ns / 1ps
`default_nettype none

module sfpr_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 rx_stall,
  input wire                 res_valid,
  input wire                 res_stall,
  input sfpr_pkg::res_item_t res_item
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("stalled result changed");

  // A status code appears only with a frame end, never the unused code
  a_status: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_item.packet_done || res_item.frame_status == sfpr_pkg::STATUS_OK)
                  && res_item.frame_status != sfpr_pkg::STATUS_NONE)
    else $error("frame status without frame end");

  // No buffer write means zero index and data
  a_nowrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.buf_write |-> res_item.buf_index == 9'd0
                                         && res_item.buf_data == 8'd0)
    else $error("index or data set without a buffer write");

  // The input stalls only while a result waits stalled
  a_stall: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> $past(res_valid) && $past(res_stall))
    else $error("input stalled with the output stage draining");

  // Nothing is delivered straight out of reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !res_valid && !rx_stall)
    else $error("output stage not empty after reset");

endmodule

bind sync_framed_packet_receiver sfpr_checker u_sfpr_checker (
  .clk       (clk),
  .rst       (rst),
  .rx_stall  (rx_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_item  (res_item)
);

`default_nettype wire
